FILE: src/depth_preferred_transposition_table_macros.svh
// Assertion macros used by the checker file of the transposition table.
`ifndef DEPTH_PREFERRED_TRANSPOSITION_TABLE_MACROS_SVH
`define DEPTH_PREFERRED_TRANSPOSITION_TABLE_MACROS_SVH

// Property checked at every clock edge outside reset.
`define DPTT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every clock edge, reset included.
`define DPTT_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/dptt_pkg.sv
// Types and constants of the depth-preferred transposition table.
package dptt_pkg;

   localparam int TABLE_BITS = 10;
   localparam int SLOT_BITS  = TABLE_BITS + 1;
   localparam int SLOTS      = 1 << SLOT_BITS;
   localparam int EPOCH_BITS = 8;

   typedef enum logic [1:0] {
      CMD_STORE = 2'd0,
      CMD_FIND  = 2'd1,
      CMD_FLUSH = 2'd2
   } cmd_type;

   typedef struct packed {
      logic [31:0]        key;
      logic [31:0]        lock;
      logic [1:0]         kind;
      logic signed [15:0] score;
      logic signed [7:0]  depth;
      logic [15:0]        best_move;
   } entry_type;

   typedef struct packed {
      logic                  valid;
      logic                  stale;
      logic [EPOCH_BITS-1:0] epoch;
   } meta_type;

   localparam logic signed [7:0] MISS_DEPTH       = -8'sd1;
   localparam logic [31:0]       COLOR_MASK_RESET = 32'd1;

endpackage

FILE: src/depth_preferred_transposition_table.sv
// Top level of the two-bank depth-preferred transposition table.
//
// Input channel req_*: one command per transfer (store, find or flush).
// Result channel rsp_*: exactly one result per command, in order; a store,
// a flush and a find that misses return the miss result (depth -1,
// was_stale 1, other fields 0).
// Configuration: csr_wr_en with csr_wr_data writes the color bit mask at
// once; write it only while the block is idle.
// For each command the accept cycle issues the slot read, the check cycle
// checks the entry and writes it back. That read-modify-write on the entry
// and tag memories lets a new command in only after the last one leaves its check cycle.
// The result register loads at the end of the check cycle; while it holds
// an unaccepted result the next command is still accepted and waits in its
// check cycle until the result register frees.
// Flush bumps an epoch counter; every 256th flush instead runs a tag sweep
// over all 2048 slots in which req_ready stays low.
// After reset a clearing pass walks all 2048 slots with req_ready low;
// configuration writes are taken during it.
module depth_preferred_transposition_table
   import dptt_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_command,
   input  logic [31:0]        req_key,
   input  logic [31:0]        req_lock,
   input  logic               req_side,
   input  logic [1:0]         req_bound_kind,
   input  logic signed [15:0] req_score,
   input  logic signed [7:0]  req_depth,
   input  logic [15:0]        req_best_move,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_hit,
   output logic [1:0]         rsp_found_kind,
   output logic signed [15:0] rsp_found_score,
   output logic signed [7:0]  rsp_found_depth,
   output logic [15:0]        rsp_found_move,
   output logic               rsp_was_stale,
   input  logic               csr_wr_en,
   input  logic [31:0]        csr_wr_data
);

   typedef enum logic [1:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_LOOKUP
   } state_type;

   state_type             state_ff;
   logic [31:0]           color_mask_ff;
   logic [EPOCH_BITS-1:0] epoch_ff;
   logic                  sweep_clear_ff;
   logic [SLOT_BITS:0]    sweep_cnt_ff;
   logic                  sweep_wpend_ff;
   logic [SLOT_BITS-1:0]  sweep_wa_ff;

   logic [1:0]            cmd_ff;
   logic [SLOT_BITS-1:0]  addr_ff;
   entry_type             ent_ff;

   logic                  rsp_valid_ff;
   logic                  rsp_hit_ff;
   logic [1:0]            rsp_kind_ff;
   logic signed [15:0]    rsp_score_ff;
   logic signed [7:0]     rsp_depth_ff;
   logic [15:0]           rsp_move_ff;
   logic                  rsp_stale_ff;

   entry_type             entry_mem [SLOTS];
   meta_type              meta_mem  [SLOTS];
   entry_type             entry_rd_ff;
   meta_type              meta_rd_ff;

   logic                  req_bank;
   logic [SLOT_BITS-1:0]  req_addr;
   logic                  mem_rd_en;
   logic [SLOT_BITS-1:0]  mem_rd_addr;
   logic                  entry_we;
   logic                  meta_we;
   logic [SLOT_BITS-1:0]  mem_wr_addr;
   meta_type              meta_wdata;
   logic                  slot_stale;
   logic                  key_match;
   logic                  store_take;
   logic                  out_free;
   logic                  lookup_done;

   // Stores pick the bank from the key under the color mask, finds from side.
   assign req_bank  = (req_command == CMD_STORE) ? (|(req_key & color_mask_ff)) : req_side;
   assign req_addr  = {req_bank, req_key[TABLE_BITS-1:0]};
   assign req_ready = (state_ff == ST_IDLE);

   assign slot_stale  = meta_rd_ff.stale || (meta_rd_ff.epoch != epoch_ff);
   assign key_match   = meta_rd_ff.valid && (entry_rd_ff.key == ent_ff.key)
                        && (entry_rd_ff.lock == ent_ff.lock);
   assign store_take  = !meta_rd_ff.valid || slot_stale
                        || ($signed(entry_rd_ff.depth) <= $signed(ent_ff.depth));
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign lookup_done = (state_ff == ST_LOOKUP) && out_free;

   always_comb begin
      mem_rd_en   = 1'b0;
      mem_rd_addr = req_addr;
      entry_we    = 1'b0;
      meta_we     = 1'b0;
      mem_wr_addr = addr_ff;
      meta_wdata  = '{valid: 1'b1, stale: 1'b0, epoch: epoch_ff};
      case (state_ff)
         ST_SWEEP: begin
            // Read one slot ahead, write back the previous one marked stale.
            mem_rd_en   = !sweep_cnt_ff[SLOT_BITS];
            mem_rd_addr = sweep_cnt_ff[SLOT_BITS-1:0];
            meta_we     = sweep_wpend_ff;
            mem_wr_addr = sweep_wa_ff;
            meta_wdata  = '{valid: !sweep_clear_ff && meta_rd_ff.valid,
                            stale: 1'b1, epoch: '0};
         end
         ST_IDLE: begin
            mem_rd_en = req_valid;
         end
         ST_LOOKUP: begin
            if (lookup_done && (cmd_ff == CMD_STORE) && store_take) begin
               entry_we = 1'b1;
               meta_we  = 1'b1;
            end
            // A hit clears the stale mark and takes the current epoch.
            if (lookup_done && (cmd_ff == CMD_FIND) && key_match) begin
               meta_we = 1'b1;
            end
         end
         default: begin
            mem_rd_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (entry_we) begin
         entry_mem[mem_wr_addr] <= ent_ff;
      end
      if (meta_we) begin
         meta_mem[mem_wr_addr] <= meta_wdata;
      end
      if (mem_rd_en) begin
         entry_rd_ff <= entry_mem[mem_rd_addr];
         meta_rd_ff  <= meta_mem[mem_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_SWEEP;
         color_mask_ff  <= COLOR_MASK_RESET;
         epoch_ff       <= '0;
         sweep_clear_ff <= 1'b1;
         sweep_cnt_ff   <= '0;
         sweep_wpend_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            color_mask_ff <= csr_wr_data;
         end
         if (lookup_done) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_SWEEP: begin
               if (!sweep_cnt_ff[SLOT_BITS]) begin
                  sweep_wa_ff    <= sweep_cnt_ff[SLOT_BITS-1:0];
                  sweep_wpend_ff <= 1'b1;
                  sweep_cnt_ff   <= sweep_cnt_ff + 1'b1;
               end else begin
                  sweep_wpend_ff <= 1'b0;
                  if (!sweep_wpend_ff) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            ST_IDLE: begin
               if (req_valid) begin
                  cmd_ff           <= req_command;
                  addr_ff          <= req_addr;
                  ent_ff.key       <= req_key;
                  ent_ff.lock      <= req_lock;
                  ent_ff.kind      <= req_bound_kind;
                  ent_ff.score     <= req_score;
                  ent_ff.depth     <= req_depth;
                  ent_ff.best_move <= req_best_move;
                  state_ff         <= ST_LOOKUP;
               end
            end
            ST_LOOKUP: begin
               if (out_free) begin
                  if ((cmd_ff == CMD_FIND) && key_match) begin
                     rsp_hit_ff   <= 1'b1;
                     rsp_kind_ff  <= entry_rd_ff.kind;
                     rsp_score_ff <= entry_rd_ff.score;
                     rsp_depth_ff <= entry_rd_ff.depth;
                     rsp_move_ff  <= entry_rd_ff.best_move;
                     rsp_stale_ff <= slot_stale;
                  end else begin
                     rsp_hit_ff   <= 1'b0;
                     rsp_kind_ff  <= '0;
                     rsp_score_ff <= '0;
                     rsp_depth_ff <= MISS_DEPTH;
                     rsp_move_ff  <= '0;
                     rsp_stale_ff <= 1'b1;
                  end
                  if ((cmd_ff == CMD_FLUSH) && (&epoch_ff)) begin
                     // Epoch about to wrap: mark every tag stale by a sweep.
                     epoch_ff       <= '0;
                     sweep_clear_ff <= 1'b0;
                     sweep_cnt_ff   <= '0;
                     sweep_wpend_ff <= 1'b0;
                     state_ff       <= ST_SWEEP;
                  end else begin
                     state_ff <= ST_IDLE;
                     if (cmd_ff == CMD_FLUSH) begin
                        epoch_ff <= epoch_ff + 1'b1;
                     end
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_found_kind  = rsp_kind_ff;
   assign rsp_found_score = rsp_score_ff;
   assign rsp_found_depth = rsp_depth_ff;
   assign rsp_found_move  = rsp_move_ff;
   assign rsp_was_stale   = rsp_stale_ff;

endmodule

FILE: src/dptt_checker.sv
// Port-level checker of the transposition table and its bind statement.
`include "depth_preferred_transposition_table_macros.svh"

module dptt_checker
   import dptt_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic [1:0]         req_command,
   input logic [31:0]        req_key,
   input logic [31:0]        req_lock,
   input logic               req_side,
   input logic [1:0]         req_bound_kind,
   input logic signed [15:0] req_score,
   input logic signed [7:0]  req_depth,
   input logic [15:0]        req_best_move,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_hit,
   input logic [1:0]         rsp_found_kind,
   input logic signed [15:0] rsp_found_score,
   input logic signed [7:0]  rsp_found_depth,
   input logic [15:0]        rsp_found_move,
   input logic               rsp_was_stale,
   input logic               csr_wr_en,
   input logic [31:0]        csr_wr_data
);

   // A stalled result holds.
   `DPTT_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable({rsp_hit, rsp_found_kind, rsp_found_score, rsp_found_depth, rsp_found_move, rsp_was_stale}), "result changed while stalled")
   // The clearing pass keeps the input closed right after reset.
   `DPTT_ASSERT_ALWAYS(a_reset_sweep, clock, reset |=> !req_ready, "input open during clearing pass")
   // One command in flight: no transfer in the cycle after a transfer.
   `DPTT_ASSERT(a_one_in_flight, clock, reset, req_valid && req_ready |=> !req_ready, "back-to-back input transfer")
   // A miss always carries the empty entry.
   `DPTT_ASSERT(a_miss_values, clock, reset, rsp_valid && !rsp_hit |-> rsp_found_depth == MISS_DEPTH && rsp_was_stale && rsp_found_kind == 2'd0 && rsp_found_score == 16'sd0 && rsp_found_move == 16'd0, "miss result not empty")

endmodule

bind depth_preferred_transposition_table dptt_checker u_dptt_checker (.*);
